@@ src/fibonacci_word_symbol_lookup_macros.svh @@
// ----------------------------------------------------------------------------
// Fibonacci word symbol lookup: assertion macros
// Concurrent assertion helpers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FIBONACCI_WORD_SYMBOL_LOOKUP_MACROS_SVH
`define FIBONACCI_WORD_SYMBOL_LOOKUP_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define FWSL_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fwsl assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FWSL_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fwsl assertion failed");

`else

`define FWSL_ASSERT_SAME(name, ante, cons)
`define FWSL_ASSERT_NEXT(name, ante, cons)

`endif

`endif

@@ src/fwsl_pkg.sv @@
// ----------------------------------------------------------------------------
// Fibonacci word symbol lookup: package
// Shared widths, the Fibonacci table, the control state type and the
// control and status structs between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package fwsl_pkg;

    localparam int MAX_LEVEL = 90;
    localparam int FIB_DEPTH = MAX_LEVEL + 1;
    localparam int LVL_W     = $clog2(FIB_DEPTH);
    localparam int POS_W     = 64;
    localparam int IN_LVL_W  = 8;

    typedef logic [POS_W-1:0]  fib_t;
    typedef logic [LVL_W-1:0]  lvl_t;
    typedef fib_t              fib_table_t [0:FIB_DEPTH-1];

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } ctrl_t;

    typedef struct packed {
        logic done;
        logic is_a;
    } status_t;

    // Built at elaboration; fib(0) = 0, fib(1) = 1.
    function automatic fib_table_t fib_table();
        fib_table_t tab;
        tab[0] = '0;
        tab[1] = fib_t'(1);
        for (int i = 2; i < FIB_DEPTH; i++)
        begin
            tab[i] = tab[i-1] + tab[i-2];
        end
        return tab;
    endfunction

endpackage

@@ src/fwsl_fib_rom.sv @@
// ----------------------------------------------------------------------------
// Fibonacci word symbol lookup: Fibonacci ROM
// Synchronous-read table of fib(0) .. fib(MAX_LEVEL); the data is registered and follows the address in the next cycle.
// ----------------------------------------------------------------------------
module fwsl_fib_rom (
    input  logic          clk,
    input  fwsl_pkg::lvl_t addr,
    output fwsl_pkg::fib_t data
);
    import fwsl_pkg::*;

    localparam fib_table_t FIB_TABLE = fib_table();

    fib_t data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= FIB_TABLE[addr];
    end

    assign data = data_reg;

endmodule

@@ src/fwsl_datapath.sv @@
// ----------------------------------------------------------------------------
// Fibonacci word symbol lookup: descent datapath
// Holds the level and position, performs one compare and subtract per cycle
// while stepping, and steers the ROM address to the next level's left length.
// ----------------------------------------------------------------------------
`include "fibonacci_word_symbol_lookup_macros.svh"

module fwsl_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fwsl_pkg::ctrl_t               ctrl,
    input  logic [fwsl_pkg::IN_LVL_W-1:0] level,
    input  fwsl_pkg::fib_t                position,
    input  fwsl_pkg::fib_t                fib_q,
    output fwsl_pkg::lvl_t                rom_addr,
    output fwsl_pkg::status_t             status
);
    import fwsl_pkg::*;

    lvl_t lvl_reg;
    lvl_t lvl_next;
    fib_t k_reg;
    fib_t k_next;
    lvl_t lvl_clamped;
    logic go_right;

    assign lvl_clamped = (level > IN_LVL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : level[LVL_W-1:0];

    // fib_q always holds fib(lvl_reg - 1), because the address below is
    // taken from the level that is about to be registered.
    assign go_right = (k_reg >= fib_q);

    always_comb
    begin
        lvl_next = lvl_reg;
        k_next   = k_reg;
        if (ctrl.load)
        begin
            lvl_next = lvl_clamped;
            k_next   = position;
        end
        else if (ctrl.step)
        begin
            if (go_right)
            begin
                lvl_next = lvl_reg - LVL_W'(1);
                k_next   = k_reg - fib_q;
            end
            else
            begin
                lvl_next = lvl_reg - LVL_W'(2);
            end
        end
        rom_addr = (lvl_next == '0) ? '0 : lvl_next - LVL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg <= '0;
        end
        else
        begin
            lvl_reg <= lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
    end

    assign status.done = (lvl_reg < LVL_W'(2));
    assign status.is_a = (lvl_reg == LVL_W'(1));

    `FWSL_ASSERT_SAME(a_lvl_in_range, 1'b1, lvl_reg <= LVL_W'(MAX_LEVEL))
    `FWSL_ASSERT_NEXT(a_step_descends, ctrl.step && !ctrl.load && !status.done,
                      lvl_reg < $past(lvl_reg))

endmodule

@@ src/fibonacci_word_symbol_lookup.sv @@
// ----------------------------------------------------------------------------
// Fibonacci word symbol lookup: top level
// Returns the symbol at a position of a level-n Fibonacci word.
// ----------------------------------------------------------------------------
// Usage:
//   A word (level, position) is taken at a rising edge where start is high and
//   busy is low. Levels above 90 are treated as 90. The block then walks down
//   the word one level step per cycle: each step compares the position with
//   the left part's length from a Fibonacci ROM and either subtracts it and
//   drops one level, or drops two levels.
//   The result is_a (1 = A, 0 = H) appears with done high for exactly one
//   cycle. The number of level steps is 0 for levels 0 and 1 and at most 89.
//   The ROM read of one Fibonacci value per cycle sets the pace, and the
//   block takes no new word until the result of the last one is out.
//   A new word may be started in the cycle in which done is high.
//   The receiver cannot stall the result. Reset returns the block to idle
//   with busy and done low; no word in flight survives it.
// ----------------------------------------------------------------------------
`include "fibonacci_word_symbol_lookup_macros.svh"

module fibonacci_word_symbol_lookup (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [fwsl_pkg::IN_LVL_W-1:0] level,
    input  logic [fwsl_pkg::POS_W-1:0]    position,
    output logic                          done,
    output logic                          is_a
);
    import fwsl_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    ctrl_t   ctrl;
    status_t status;
    lvl_t    rom_addr;
    fib_t    fib_q;
    logic    done_reg;
    logic    done_next;
    logic    is_a_reg;
    logic    is_a_next;

    fwsl_fib_rom u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (fib_q)
    );

    fwsl_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .level    (level),
        .position (position),
        .fib_q    (fib_q),
        .rom_addr (rom_addr),
        .status   (status)
    );

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        done_next  = 1'b0;
        is_a_next  = is_a_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.done)
                begin
                    done_next  = 1'b1;
                    is_a_next  = status.is_a;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctrl.step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_a_reg <= is_a_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign is_a = is_a_reg;

    `FWSL_ASSERT_SAME(a_done_when_idle, done, !busy)
    `FWSL_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
    `FWSL_ASSERT_NEXT(a_single_result, done, !done)

endmodule

@@ tb/fwsl_symbol_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fibonacci word symbol checker
// Watches the command and result ports of the symbol lookup, predicts the
// symbol for every accepted word and compares it with the next result.
// ----------------------------------------------------------------------------
module fwsl_symbol_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [fwsl_pkg::IN_LVL_W-1:0] level,
    input  logic [fwsl_pkg::POS_W-1:0]    position,
    input  logic                          done,
    input  logic                          is_a,
    output int                            error_count,
    output int                            pending,
    output int                            checked,
    output int                            a_count
);

    import fwsl_pkg::*;

    fib_t fib_len [0:MAX_LEVEL];
    logic expected_symbols [$];

    initial
    begin
        fib_len[0] = '0;
        fib_len[1] = fib_t'(1);
        for (int i = 2; i <= MAX_LEVEL; i++)
        begin
            fib_len[i] = fib_len[i-1] + fib_len[i-2];
        end
    end

    // Walk down the word: the left part of level n is S(n-2), of length fib(n-1).
    function automatic logic symbol_at(input logic [IN_LVL_W-1:0] lvl_in, input fib_t pos);
        int unsigned n;
        fib_t        k;
        n = (lvl_in > MAX_LEVEL) ? MAX_LEVEL : lvl_in;
        k = pos;
        while (n >= 2)
        begin
            if (k >= fib_len[n-1])
            begin
                k = k - fib_len[n-1];
                n = n - 1;
            end
            else
            begin
                n = n - 2;
            end
        end
        return (n == 1);
    endfunction

    initial
    begin
        error_count = 0;
        pending     = 0;
        checked     = 0;
        a_count     = 0;
    end

    always @(posedge clk)
    begin
        logic want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_symbols.size() == 0)
                begin
                    $error("result with no word outstanding: is_a=%0b", is_a);
                    error_count++;
                end
                else
                begin
                    want = expected_symbols.pop_front();
                    if (is_a !== want)
                    begin
                        $error("is_a mismatch: expected %0b, actual %0b", want, is_a);
                        error_count++;
                    end
                    checked++;
                    if (want)
                    begin
                        a_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                expected_symbols.push_back(symbol_at(level, position));
            end
            pending = expected_symbols.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fibonacci word symbol lookup testbench
// Drives directed corner words and then shaped random words with random
// gaps into the lookup; a checker beside the block predicts every symbol.
// ----------------------------------------------------------------------------
module testbench;

    import fwsl_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [IN_LVL_W-1:0] level;
    logic [POS_W-1:0]    position;
    logic                done;
    logic                is_a;

    int   error_count;
    int   pending;
    int   checked;
    int   a_count;
    int   words_sent;
    logic sender_idles;

    // Word lengths: level n is fib(n+1) symbols long; fib(91) still fits 64 bits.
    fib_t word_fib [0:MAX_LEVEL+1];

    fibonacci_word_symbol_lookup u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .level    (level),
        .position (position),
        .done     (done),
        .is_a     (is_a)
    );

    fwsl_symbol_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .level       (level),
        .position    (position),
        .done        (done),
        .is_a        (is_a),
        .error_count (error_count),
        .pending     (pending),
        .checked     (checked),
        .a_count     (a_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic fib_t rand64();
        return {$urandom, $urandom};
    endfunction

    // Start stays high across back-to-back words; it only drops for a gap or when results are drained.
    task automatic send_word(input int unsigned lvl, input fib_t pos);
        int unsigned gap;
        gap = sender_idles ? $urandom_range(0, 8) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start    <= 1'b1;
        level    <= lvl[IN_LVL_W-1:0];
        position <= pos;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        words_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        wait (pending == 0);
    endtask

    initial
    begin
        int unsigned n;
        int unsigned m;
        fib_t        pos;

        start        = 1'b0;
        level        = '0;
        position     = '0;
        rst_n        = 1'b0;
        words_sent   = 0;
        sender_idles = 1'b0;
        word_fib[0]  = '0;
        word_fib[1]  = fib_t'(1);
        for (int i = 2; i <= MAX_LEVEL + 1; i++)
        begin
            word_fib[i] = word_fib[i-1] + word_fib[i-2];
        end
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed corners: trivial levels, boundaries, past-the-end and clamped levels.
        send_word(0, '0);
        send_word(0, '1);
        send_word(1, '0);
        send_word(1, '1);
        send_word(2, 0);
        send_word(2, 1);
        send_word(2, 2);
        send_word(3, 0);
        send_word(3, 1);
        send_word(3, 2);
        send_word(5, 7);
        send_word(10, word_fib[11] - 1);
        send_word(90, '0);
        send_word(90, word_fib[89] - 1);
        send_word(90, word_fib[89]);
        send_word(90, word_fib[91] - 1);
        send_word(90, word_fib[91]);
        send_word(90, '1);
        send_word(89, word_fib[88]);
        send_word(91, 123);
        send_word(255, '1);
        send_word(255, '0);
        send_word(128, 64'h5555_5555_5555_5555);
        send_word(64, 64'hAAAA_AAAA_AAAA_AAAA);
        drain_results();

        for (int phase = 0; phase < 11; phase++)
        begin
            sender_idles = ($urandom_range(0, 3) != 0);
            for (int item = 0; item < 50; item++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4:
                    begin
                        n   = $urandom_range(2, MAX_LEVEL);
                        pos = rand64() % word_fib[n+1];
                    end
                    5:
                    begin
                        // Land on or next to a left-part boundary.
                        n   = $urandom_range(2, MAX_LEVEL);
                        m   = $urandom_range(1, n);
                        pos = word_fib[m] - 1 + fib_t'($urandom_range(0, 2));
                    end
                    6:
                    begin
                        n   = $urandom_range(0, 255);
                        pos = rand64();
                    end
                    7:
                    begin
                        n   = $urandom_range(MAX_LEVEL + 1, 255);
                        pos = $urandom_range(0, 1) ? rand64() % word_fib[MAX_LEVEL+1] : rand64();
                    end
                    8:
                    begin
                        n   = $urandom_range(0, 6);
                        pos = $urandom_range(0, 20);
                    end
                    default:
                    begin
                        n   = $urandom_range(0, 255);
                        pos = rand64() >> $urandom_range(0, 63);
                    end
                endcase
                send_word(n, pos);
            end
            if (phase == 3 || phase == 7)
            begin
                drain_results();
            end
        end

        drain_results();
        repeat (2 * MAX_LEVEL) @(posedge clk);

        $display("Sent %0d words over levels 0 to 255 and positions up to all ones.", words_sent);
        $display("Checked %0d symbols: %0d A and %0d H.", checked, a_count, checked - a_count);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
